/* hdl/tqfs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the tenant quota / fair-share table.
// No dependencies; imported by tqfs_div and tenant_quota_fair_share_table.
package tqfs_pkg;

    // Field widths
    localparam int ACT_W     = 4;
    localparam int ID_W      = 16;
    localparam int RES_W     = 3;
    localparam int DATA_W    = 32;
    localparam int WT_IN_W   = 16;
    localparam int WT_W      = 7;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;
    // current * 100 fits in 32 + 7 bits
    localparam int SCORE_W   = DATA_W + WT_W;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_CREATE  = 4'd0;
    localparam logic [ACT_W-1:0] ACT_DESTROY = 4'd1;
    localparam logic [ACT_W-1:0] ACT_SET_LIM = 4'd2;
    localparam logic [ACT_W-1:0] ACT_SET_ACT = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SET_WT  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_CHECK   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ACCOUNT = 4'd6;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 4'd7;
    localparam logic [ACT_W-1:0] ACT_SELECT  = 4'd8;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 4'd9;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    localparam logic [WT_W-1:0]   WEIGHT_MAX = 7'd100;
    localparam logic [DATA_W-1:0] SAT32      = 32'hFFFF_FFFF;
    localparam logic [ID_W-1:0]   ID_FIRST   = 16'd1;
    localparam logic [ID_W-1:0]   ID_LAST    = 16'hFFFF;

    // Per-slot memory word
    typedef struct packed {
        logic              active;
        logic [ID_W-1:0]   id;
        logic [WT_W-1:0]   weight;
        logic [DATA_W-1:0] denials;
    } slot_word_t;

    // Per-slot, per-resource memory word
    typedef struct packed {
        logic [DATA_W-1:0] limit;
        logic [DATA_W-1:0] current;
        logic [DATA_W-1:0] peak;
        logic [DATA_W-1:0] total;
    } res_word_t;

    // Weight clamp to 1..100
    function automatic logic [WT_W-1:0] clamp_weight(input logic [WT_IN_W-1:0] w);
        logic [WT_W-1:0] r;
        if (w == '0)
            r = WT_W'(1);
        else if (w > WT_IN_W'(WEIGHT_MAX))
            r = WEIGHT_MAX;
        else
            r = w[WT_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/tqfs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tqfs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tqfs_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for fair-share scores.
// Depends on tqfs_pkg.
module tqfs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tqfs_pkg::SCORE_W-1:0]  dividend,
    input  logic [tqfs_pkg::WT_W-1:0]     divisor,
    output logic                          done,
    output logic [tqfs_pkg::SCORE_W-1:0]  quotient
);
    import tqfs_pkg::*;

    localparam int STEP_W = $clog2(SCORE_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SCORE_W - 1);

    logic [SCORE_W-1:0] quo_reg, quo_next;
    logic [WT_W-1:0]    rem_reg, rem_next;
    logic [WT_W-1:0]    dvs_reg, dvs_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [WT_W:0]      trial;
    logic [WT_W:0]      diff;
    logic               ge;

    // One restoring step
    assign trial = {rem_reg, quo_reg[SCORE_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WT_W-1:0] : trial[WT_W-1:0];
            quo_next = {quo_reg[SCORE_W-2:0], ge};
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/tenant_quota_fair_share_table.sv */
`timescale 1ns / 1ps
// Tenant quota table with weighted fair-share selection.
// Flow to out_valid: create finds the lowest free slot, then zeroes its resource rows; per-tenant
// requests search the slot RAM for the id, lowest slot first, then act; select scans every slot
// with one divide per eligible tenant; bad requests go straight to the result.
// One request in flight; in_ready returns in the cycle out_valid rises, later if a result waits.
// Reset (async, rst_n low) clears slot valid bits and counters; RAMs need no clear.
module tenant_quota_fair_share_table #(
    parameter int NUM_SLOTS     = 16,
    parameter int NUM_RESOURCES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tqfs_pkg::ACT_W-1:0]      action,
    input  logic [tqfs_pkg::ID_W-1:0]       tenant,
    input  logic [tqfs_pkg::RES_W-1:0]      resource,
    input  logic [tqfs_pkg::DATA_W-1:0]     amount,
    input  logic [tqfs_pkg::WT_IN_W-1:0]    weight,
    input  logic                            active_flag,
    input  logic [tqfs_pkg::DATA_W-1:0]     limit_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tqfs_pkg::STAT_W-1:0]     status,
    output logic                            allowed,
    output logic [tqfs_pkg::ID_W-1:0]       result_id,
    output logic [tqfs_pkg::DATA_W-1:0]     usage_now,
    output logic [tqfs_pkg::DATA_W-1:0]     usage_peak,
    output logic [tqfs_pkg::DATA_W-1:0]     usage_total,
    output logic [tqfs_pkg::DATA_W-1:0]     denials,
    output logic [tqfs_pkg::CNT_OUT_W-1:0]  active_count
);
    import tqfs_pkg::*;

    localparam int SW   = $clog2(NUM_SLOTS);
    localparam int RC_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int RA_W = $clog2(NUM_SLOTS * NUM_RESOURCES);
    localparam int UC_W = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0]   LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [RC_W-1:0] LAST_RES  = RC_W'(NUM_RESOURCES - 1);
    localparam logic [SW:0]     MT_EXT    = (SW + 1)'(NUM_SLOTS);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_FREE     = 11'b000_0000_0010,
        S_CLEAR    = 11'b000_0000_0100,
        S_LOOK_RD  = 11'b000_0000_1000,
        S_LOOK_CHK = 11'b000_0001_0000,
        S_OP_RD    = 11'b000_0010_0000,
        S_OP_EXE   = 11'b000_0100_0000,
        S_SEL_RD   = 11'b000_1000_0000,
        S_SEL_CHK  = 11'b001_0000_0000,
        S_SEL_DIV  = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic [RC_W-1:0]    rc_reg, rc_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [ID_W-1:0]    tid_reg, tid_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [DATA_W-1:0]  amt_reg, amt_next;
    logic [WT_IN_W-1:0] wt_reg, wt_next;
    logic               aflag_reg, aflag_next;
    logic [DATA_W-1:0]  lim_reg, lim_next;
    slot_word_t         sq_reg, sq_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [UC_W-1:0]    ucnt_reg, ucnt_next;
    logic [ID_W-1:0]    nid_reg, nid_next;
    logic [SW-1:0]      rot_reg, rot_next;
    logic               found_reg, found_next;
    logic [SCORE_W-1:0] best_reg, best_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic [ID_W-1:0]    cand_id_reg, cand_id_next;
    // result being built
    logic [STAT_W-1:0]  r_status_reg, r_status_next;
    logic               r_allowed_reg, r_allowed_next;
    logic [ID_W-1:0]    r_id_reg, r_id_next;
    logic [DATA_W-1:0]  r_now_reg, r_now_next;
    logic [DATA_W-1:0]  r_peak_reg, r_peak_next;
    logic [DATA_W-1:0]  r_total_reg, r_total_next;
    logic [DATA_W-1:0]  r_den_reg, r_den_next;
    // output register
    logic               ov_reg, ov_next;
    logic [STAT_W-1:0]  o_status_reg, o_status_next;
    logic               o_allowed_reg, o_allowed_next;
    logic [ID_W-1:0]    o_id_reg, o_id_next;
    logic [DATA_W-1:0]  o_now_reg, o_now_next;
    logic [DATA_W-1:0]  o_peak_reg, o_peak_next;
    logic [DATA_W-1:0]  o_total_reg, o_total_next;
    logic [DATA_W-1:0]  o_den_reg, o_den_next;
    logic [CNT_OUT_W-1:0] o_cnt_reg, o_cnt_next;

    // memory ports
    logic               slot_we;
    logic [SW-1:0]      slot_waddr, slot_raddr;
    slot_word_t         slot_wdata, slot_rd;
    logic               res_we;
    logic [RA_W-1:0]    res_waddr, res_raddr;
    res_word_t          res_wdata, res_rd;

    // divider
    logic               div_start, div_done;
    logic [SCORE_W-1:0] div_dividend, div_quot;

    logic               in_xfer, res_ok_in, needs_res_in;
    logic [SW:0]        sel_sum, rot_inc;
    logic [SW-1:0]      sel_idx;
    logic [RA_W-1:0]    op_addr, sel_addr, clr_addr;
    logic [DATA_W:0]    sum33;
    logic               sel_step;

    tqfs_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(NUM_SLOTS), .ADDR_W(SW)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rd)
    );

    tqfs_ram #(.WIDTH($bits(res_word_t)), .DEPTH(NUM_SLOTS * NUM_RESOURCES),
               .ADDR_W(RA_W)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rd)
    );

    tqfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (slot_rd.weight),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Request decode at the input
    assign in_ready     = (state_reg == S_IDLE);
    assign in_xfer      = in_valid && in_ready;
    assign res_ok_in    = CNT_OUT_W'(resource) < CNT_OUT_W'(NUM_RESOURCES);
    assign needs_res_in = (action == ACT_SET_LIM) || (action == ACT_CHECK) ||
                          (action == ACT_ACCOUNT) || (action == ACT_RELEASE) ||
                          (action == ACT_QUERY);

    // Rotated scan index and resource RAM addresses
    assign sel_sum  = {1'b0, rot_reg} + {1'b0, cnt_reg};
    assign sel_idx  = (sel_sum >= MT_EXT) ? SW'(sel_sum - MT_EXT) : sel_sum[SW-1:0];
    assign rot_inc  = {1'b0, rot_reg} + (SW + 1)'(1);
    assign op_addr  = RA_W'(slot_reg) * RA_W'(NUM_RESOURCES) + RA_W'(res_reg);
    assign sel_addr = RA_W'(sel_idx) * RA_W'(NUM_RESOURCES) + RA_W'(res_reg);
    assign clr_addr = RA_W'(slot_reg) * RA_W'(NUM_RESOURCES) + RA_W'(rc_reg);
    assign sum33    = {1'b0, res_rd.current} + {1'b0, amt_reg};
    assign div_dividend = SCORE_W'(res_rd.current) * SCORE_W'(WEIGHT_MAX);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rc_next        = rc_reg;
        slot_next      = slot_reg;
        act_next       = act_reg;
        tid_next       = tid_reg;
        res_next       = res_reg;
        amt_next       = amt_reg;
        wt_next        = wt_reg;
        aflag_next     = aflag_reg;
        lim_next       = lim_reg;
        sq_next        = sq_reg;
        used_next      = used_reg;
        ucnt_next      = ucnt_reg;
        nid_next       = nid_reg;
        rot_next       = rot_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_id_next   = best_id_reg;
        cand_id_next   = cand_id_reg;
        r_status_next  = r_status_reg;
        r_allowed_next = r_allowed_reg;
        r_id_next      = r_id_reg;
        r_now_next     = r_now_reg;
        r_peak_next    = r_peak_reg;
        r_total_next   = r_total_reg;
        r_den_next     = r_den_reg;
        ov_next        = ov_reg && !out_ready;
        o_status_next  = o_status_reg;
        o_allowed_next = o_allowed_reg;
        o_id_next      = o_id_reg;
        o_now_next     = o_now_reg;
        o_peak_next    = o_peak_reg;
        o_total_next   = o_total_reg;
        o_den_next     = o_den_reg;
        o_cnt_next     = o_cnt_reg;
        slot_we        = 1'b0;
        slot_waddr     = slot_reg;
        slot_wdata     = sq_reg;
        slot_raddr     = cnt_reg;
        res_we         = 1'b0;
        res_waddr      = op_addr;
        res_wdata      = res_rd;
        res_raddr      = op_addr;
        div_start      = 1'b0;
        sel_step       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    act_next       = action;
                    tid_next       = tenant;
                    res_next       = resource;
                    amt_next       = amount;
                    wt_next        = weight;
                    aflag_next     = active_flag;
                    lim_next       = limit_value;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    r_status_next  = ST_OK;
                    r_allowed_next = 1'b0;
                    r_id_next      = '0;
                    r_now_next     = '0;
                    r_peak_next    = '0;
                    r_total_next   = '0;
                    r_den_next     = '0;
                    if (action == ACT_CREATE)
                    begin
                        state_next = S_FREE;
                    end
                    else if (action == ACT_SELECT)
                    begin
                        if (res_ok_in)
                        begin
                            state_next = S_SEL_RD;
                        end
                        else
                        begin
                            r_status_next = ST_BAD;
                            state_next    = S_DONE;
                        end
                    end
                    else if (action <= ACT_QUERY)
                    begin
                        if (needs_res_in && !res_ok_in)
                        begin
                            r_status_next = ST_BAD;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LOOK_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // lowest free slot
            S_FREE:
            begin
                if (!used_reg[cnt_reg])
                begin
                    slot_next  = cnt_reg;
                    slot_we    = 1'b1;
                    slot_waddr = cnt_reg;
                    slot_wdata = '{active: 1'b1, id: nid_reg,
                                   weight: clamp_weight(wt_reg), denials: '0};
                    rc_next    = '0;
                    state_next = S_CLEAR;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    r_status_next = ST_FULL;
                    state_next    = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end

            // zero the new tenant's resource rows
            S_CLEAR:
            begin
                res_we    = 1'b1;
                res_waddr = clr_addr;
                res_wdata = '0;
                if (rc_reg == LAST_RES)
                begin
                    used_next[slot_reg] = 1'b1;
                    ucnt_next  = ucnt_reg + UC_W'(1);
                    r_id_next  = nid_reg;
                    nid_next   = (nid_reg == ID_LAST) ? ID_FIRST : nid_reg + ID_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rc_next = rc_reg + RC_W'(1);
                end
            end

            S_LOOK_RD:
            begin
                slot_raddr = cnt_reg;
                state_next = S_LOOK_CHK;
            end

            // id match, lowest slot first
            S_LOOK_CHK:
            begin
                if (used_reg[cnt_reg] && (slot_rd.id == tid_reg))
                begin
                    slot_next  = cnt_reg;
                    sq_next    = slot_rd;
                    state_next = S_OP_RD;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    r_status_next = ST_BAD;
                    state_next    = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + SW'(1);
                    state_next = S_LOOK_RD;
                end
            end

            S_OP_RD:
            begin
                res_raddr  = op_addr;
                state_next = S_OP_EXE;
            end

            // read-modify-write on the addressed tenant
            S_OP_EXE:
            begin
                state_next = S_DONE;
                unique case (act_reg)
                    ACT_DESTROY:
                    begin
                        used_next[slot_reg] = 1'b0;
                        if (ucnt_reg != '0)
                        begin
                            ucnt_next = ucnt_reg - UC_W'(1);
                        end
                    end
                    ACT_SET_LIM:
                    begin
                        res_we          = 1'b1;
                        res_wdata.limit = lim_reg;
                    end
                    ACT_SET_ACT:
                    begin
                        slot_we           = 1'b1;
                        slot_wdata.active = aflag_reg;
                    end
                    ACT_SET_WT:
                    begin
                        slot_we           = 1'b1;
                        slot_wdata.weight = clamp_weight(wt_reg);
                    end
                    ACT_CHECK:
                    begin
                        if (sq_reg.active)
                        begin
                            if (sum33 > {1'b0, res_rd.limit})
                            begin
                                slot_we            = 1'b1;
                                slot_wdata.denials = sq_reg.denials + DATA_W'(1);
                            end
                            else
                            begin
                                r_allowed_next = 1'b1;
                            end
                        end
                    end
                    ACT_ACCOUNT:
                    begin
                        res_we            = 1'b1;
                        res_wdata.current = sum33[DATA_W] ? SAT32 : sum33[DATA_W-1:0];
                        res_wdata.total   = res_rd.total + amt_reg;
                        if (res_wdata.current > res_rd.peak)
                        begin
                            res_wdata.peak = res_wdata.current;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        res_we            = 1'b1;
                        res_wdata.current = (res_rd.current >= amt_reg) ?
                                            res_rd.current - amt_reg : '0;
                    end
                    ACT_QUERY:
                    begin
                        r_now_next   = res_rd.current;
                        r_peak_next  = res_rd.peak;
                        r_total_next = res_rd.total;
                        r_den_next   = sq_reg.denials;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SEL_RD:
            begin
                slot_raddr = sel_idx;
                res_raddr  = sel_addr;
                slot_next  = sel_idx;
                state_next = S_SEL_CHK;
            end

            // eligible tenants go to the divider
            S_SEL_CHK:
            begin
                if (used_reg[slot_reg] && slot_rd.active && (slot_rd.weight != '0) &&
                    (res_rd.current < res_rd.limit))
                begin
                    div_start    = 1'b1;
                    cand_id_next = slot_rd.id;
                    state_next   = S_SEL_DIV;
                end
                else
                begin
                    sel_step = 1'b1;
                end
            end

            S_SEL_DIV:
            begin
                if (div_done)
                begin
                    if (!found_reg || (div_quot < best_reg))
                    begin
                        best_next    = div_quot;
                        best_id_next = cand_id_reg;
                        found_next   = 1'b1;
                    end
                    sel_step = 1'b1;
                end
            end

            // hold until the output register is free
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next        = 1'b1;
                    o_status_next  = r_status_reg;
                    o_allowed_next = r_allowed_reg;
                    o_id_next      = r_id_reg;
                    o_now_next     = r_now_reg;
                    o_peak_next    = r_peak_reg;
                    o_total_next   = r_total_reg;
                    o_den_next     = r_den_reg;
                    o_cnt_next     = CNT_OUT_W'(ucnt_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance the fair-share scan
        if (sel_step)
        begin
            if (cnt_reg == LAST_SLOT)
            begin
                r_id_next  = found_next ? best_id_next : '0;
                rot_next   = (rot_inc == MT_EXT) ? '0 : rot_inc[SW-1:0];
                state_next = S_DONE;
            end
            else
            begin
                cnt_next   = cnt_reg + SW'(1);
                state_next = S_SEL_RD;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ucnt_reg  <= '0;
            nid_reg   <= ID_FIRST;
            rot_reg   <= '0;
            ov_reg    <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            rc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ucnt_reg  <= ucnt_next;
            nid_reg   <= nid_next;
            rot_reg   <= rot_next;
            ov_reg    <= ov_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
            rc_reg    <= rc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        act_reg       <= act_next;
        tid_reg       <= tid_next;
        res_reg       <= res_next;
        amt_reg       <= amt_next;
        wt_reg        <= wt_next;
        aflag_reg     <= aflag_next;
        lim_reg       <= lim_next;
        sq_reg        <= sq_next;
        best_reg      <= best_next;
        best_id_reg   <= best_id_next;
        cand_id_reg   <= cand_id_next;
        r_status_reg  <= r_status_next;
        r_allowed_reg <= r_allowed_next;
        r_id_reg      <= r_id_next;
        r_now_reg     <= r_now_next;
        r_peak_reg    <= r_peak_next;
        r_total_reg   <= r_total_next;
        r_den_reg     <= r_den_next;
        o_status_reg  <= o_status_next;
        o_allowed_reg <= o_allowed_next;
        o_id_reg      <= o_id_next;
        o_now_reg     <= o_now_next;
        o_peak_reg    <= o_peak_next;
        o_total_reg   <= o_total_next;
        o_den_reg     <= o_den_next;
        o_cnt_reg     <= o_cnt_next;
    end

    assign out_valid    = ov_reg;
    assign status       = o_status_reg;
    assign allowed      = o_allowed_reg;
    assign result_id    = o_id_reg;
    assign usage_now    = o_now_reg;
    assign usage_peak   = o_peak_reg;
    assign usage_total  = o_total_reg;
    assign denials      = o_den_reg;
    assign active_count = o_cnt_reg;

    // Checks
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ucnt_reg) == $countones(used_reg))
        else $error("used count out of step with slot valid bits");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != S_IDLE)
        else $error("accepted request did not start");

    a_div_in_select: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_SEL_DIV)
        else $error("divider finished outside selection");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW + 1)'(rot_reg) < MT_EXT)
        else $error("rotation index out of range");

endmodule
